### design/nsm_pkg.sv
// Package for the note sequence matcher: note codes, pattern ROM, result type.
`default_nettype none
package nsm_pkg;

    localparam int MAX_NOTES   = 8;
    localparam int NOTE_W      = 3;
    localparam int STAMP_W     = 32;
    localparam int CFG_W       = 16;
    localparam int IDX_W       = 4;
    localparam int PERF_W      = 2;
    localparam int PAT_COUNT   = 10;
    localparam int PAT_ROW     = 7;
    localparam int LEN_W       = 3;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 8;

    typedef logic [NOTE_W-1:0] t_note;

    localparam t_note NOTE_UP    = 3'd0;
    localparam t_note NOTE_DOWN  = 3'd1;
    localparam t_note NOTE_LEFT  = 3'd2;
    localparam t_note NOTE_RIGHT = 3'd3;
    localparam t_note NOTE_A     = 3'd4;

    localparam logic [PERF_W-1:0] PERF_FORWARD  = 2'd0;
    localparam logic [PERF_W-1:0] PERF_REVERSED = 2'd1;
    localparam logic [PERF_W-1:0] PERF_DOUBLED  = 2'd2;

    // configuration register indexes
    localparam logic REG_TIMEOUT = 1'b0;
    localparam logic REG_BRISK   = 1'b1;

    localparam logic [CFG_W-1:0] TIMEOUT_RESET = 16'd2000;
    localparam logic [CFG_W-1:0] BRISK_RESET   = 16'd200;

    localparam int PAT_LEN [PAT_COUNT] = '{6, 6, 6, 6, 7, 7, 7, 7, 7, 6};

    localparam t_note PAT_ROM [PAT_COUNT][PAT_ROW] = '{
        '{NOTE_UP,    NOTE_LEFT,  NOTE_RIGHT, NOTE_UP,    NOTE_LEFT,  NOTE_RIGHT, NOTE_UP},
        '{NOTE_LEFT,  NOTE_RIGHT, NOTE_DOWN,  NOTE_LEFT,  NOTE_RIGHT, NOTE_DOWN,  NOTE_UP},
        '{NOTE_A,     NOTE_UP,    NOTE_LEFT,  NOTE_A,     NOTE_UP,    NOTE_LEFT,  NOTE_UP},
        '{NOTE_UP,    NOTE_A,     NOTE_LEFT,  NOTE_RIGHT, NOTE_DOWN,  NOTE_A,     NOTE_UP},
        '{NOTE_A,     NOTE_RIGHT, NOTE_LEFT,  NOTE_A,     NOTE_RIGHT, NOTE_LEFT,  NOTE_DOWN},
        '{NOTE_LEFT,  NOTE_UP,    NOTE_LEFT,  NOTE_RIGHT, NOTE_DOWN,  NOTE_LEFT,  NOTE_RIGHT},
        '{NOTE_RIGHT, NOTE_LEFT,  NOTE_RIGHT, NOTE_DOWN,  NOTE_RIGHT, NOTE_UP,    NOTE_LEFT},
        '{NOTE_DOWN,  NOTE_A,     NOTE_RIGHT, NOTE_DOWN,  NOTE_A,     NOTE_RIGHT, NOTE_UP},
        '{NOTE_DOWN,  NOTE_LEFT,  NOTE_UP,    NOTE_RIGHT, NOTE_DOWN,  NOTE_LEFT,  NOTE_UP},
        '{NOTE_A,     NOTE_DOWN,  NOTE_UP,    NOTE_A,     NOTE_DOWN,  NOTE_UP,    NOTE_UP}
    };

    // pattern 0 may be doubled: span over its notes against interval * gaps
    localparam int DBL_GAPS  = PAT_LEN[0] - 1;
    localparam int LIMIT_W   = CFG_W + LEN_W;

    typedef struct packed {
        logic              matched;
        logic [IDX_W-1:0]  pattern_index;
        logic [PERF_W-1:0] performance;
    } t_result;

endpackage
`default_nettype wire

### design/nsm_cell.sv
// One history cell: holds a note and its timestamp, passes them on when a note enters.
`default_nettype none
module nsm_cell (
    input  wire                          i_clk,
    input  wire                          i_shift,
    input  wire  nsm_pkg::t_note         i_note,
    input  wire  [nsm_pkg::STAMP_W-1:0]  i_stamp,
    output logic [nsm_pkg::NOTE_W-1:0]   o_note,
    output logic [nsm_pkg::STAMP_W-1:0]  o_stamp
);

    nsm_pkg::t_note              r_note;
    logic [nsm_pkg::STAMP_W-1:0] r_stamp;

    // payload only; the fill count at the top says which cells are live
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_note  <= i_note;
            r_stamp <= i_stamp;
        end
    end

    assign o_note  = r_note;
    assign o_stamp = r_stamp;

endmodule
`default_nettype wire

### design/nsm_match.sv
// Pattern compare over the newest notes and winner selection.
`default_nettype none
module nsm_match #(
    parameter int CNT_W = 4
) (
    input  wire  nsm_pkg::t_note          i_win [nsm_pkg::PAT_ROW],
    input  wire  [CNT_W-1:0]              i_count,
    input  wire  [nsm_pkg::STAMP_W-1:0]   i_stamp_new,
    input  wire  [nsm_pkg::STAMP_W-1:0]   i_stamp_first,
    input  wire  [nsm_pkg::LIMIT_W-1:0]   i_limit,
    output nsm_pkg::t_result              o_result
);

    logic [nsm_pkg::PAT_COUNT-1:0] fwd;
    logic                          rev0;
    logic [nsm_pkg::STAMP_W-1:0]   span;
    logic                          brisk;

    always_comb begin
        for (int p = 0; p < nsm_pkg::PAT_COUNT; p++) begin
            fwd[p] = (CNT_W'(nsm_pkg::PAT_LEN[p]) <= i_count);
            for (int i = 0; i < nsm_pkg::PAT_ROW; i++) begin
                if (i < nsm_pkg::PAT_LEN[p]) begin
                    if (i_win[i] != nsm_pkg::PAT_ROM[p][nsm_pkg::PAT_LEN[p] - 1 - i])
                        fwd[p] = 1'b0;
                end
            end
        end
        rev0 = (CNT_W'(nsm_pkg::PAT_LEN[0]) <= i_count);
        for (int i = 0; i < nsm_pkg::PAT_LEN[0]; i++) begin
            if (i_win[i] != nsm_pkg::PAT_ROM[0][i])
                rev0 = 1'b0;
        end
    end

    assign span  = i_stamp_new - i_stamp_first;
    assign brisk = (span <= nsm_pkg::STAMP_W'(i_limit));

    // longest wins, earlier index wins a tie
    always_comb begin
        logic [nsm_pkg::LEN_W-1:0] best_len;
        best_len = '0;
        o_result = '0;
        for (int p = 0; p < nsm_pkg::PAT_COUNT; p++) begin
            if (nsm_pkg::LEN_W'(nsm_pkg::PAT_LEN[p]) > best_len) begin
                if (fwd[p]) begin
                    best_len               = nsm_pkg::LEN_W'(nsm_pkg::PAT_LEN[p]);
                    o_result.matched       = 1'b1;
                    o_result.pattern_index = nsm_pkg::IDX_W'(p);
                    o_result.performance   = (p == 0 && brisk) ? nsm_pkg::PERF_DOUBLED
                                                               : nsm_pkg::PERF_FORWARD;
                end else if (p == 0 && rev0) begin
                    best_len               = nsm_pkg::LEN_W'(nsm_pkg::PAT_LEN[p]);
                    o_result.matched       = 1'b1;
                    o_result.pattern_index = nsm_pkg::IDX_W'(p);
                    o_result.performance   = nsm_pkg::PERF_REVERSED;
                end
            end
        end
    end

endmodule
`default_nettype wire

### design/note_sequence_matcher_top.sv
// Top level of the note sequence matcher: history cell chain, matcher, output register.
//
//  channel   dir  handshake                 payload
//  --------  ---  ------------------------  -------------------------------------------
//  s_axis    in   i_s_axis_tvalid/o_tready  tdata[2:0] note, [34:3] stamp_ms
//  m_axis    out  o_m_axis_tvalid/i_tready  tdata[0] matched, [4:1] pattern_index,
//                                           [6:5] performance
//  cfg       in   i_cfg_valid/o_cfg_ready   index 0 timeout_ms, 1 brisk_interval_ms
//
// One note per cycle unless m_axis stalls, one registered result per note. The window
// compare and winner pick sit between the history cells and the output register.
// Input is taken whenever the output register is empty or drained in the same
// cycle, so a stall on m_axis backs up to s_axis after one held result.
// Reset empties the history (fill count and held flag) and loads register defaults.
`default_nettype none
module note_sequence_matcher_top #(
    parameter int MAX_NOTES = nsm_pkg::MAX_NOTES
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // input notes: [2:0] note, [34:3] stamp_ms, rest zero
    input  wire                                i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  wire  [nsm_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // results: [0] matched, [4:1] pattern_index, [6:5] performance, [7] zero
    output logic                               o_m_axis_tvalid,
    input  wire                                i_m_axis_tready,
    output logic [nsm_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // configuration writes
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire                                i_cfg_index,
    input  wire  [nsm_pkg::CFG_W-1:0]          i_cfg_data
);

    localparam int CNT_W = $clog2(MAX_NOTES + 1);

    // control state
    logic [CNT_W-1:0]               r_held_count, n_held_count;
    logic                           r_note_held,  n_note_held;
    logic [nsm_pkg::STAMP_W-1:0]    r_last_stamp;
    logic [nsm_pkg::CFG_W-1:0]      r_timeout;
    // brisk interval kept pre-scaled by the gap count of pattern 0
    logic [nsm_pkg::LIMIT_W-1:0]    r_limit;
    logic                           r_out_valid;
    nsm_pkg::t_result               r_out;

    logic                           in_xfer;
    nsm_pkg::t_note                 in_note;
    logic [nsm_pkg::STAMP_W-1:0]    in_stamp;
    logic [nsm_pkg::STAMP_W-1:0]    elapsed;
    logic                           timed_out;
    logic [CNT_W-1:0]               cnt_base;
    logic [CNT_W-1:0]               cnt_new;
    nsm_pkg::t_result               result;

    nsm_pkg::t_note                 cell_note  [MAX_NOTES];
    logic [nsm_pkg::STAMP_W-1:0]    cell_stamp [MAX_NOTES];
    nsm_pkg::t_note                 win        [nsm_pkg::PAT_ROW];

    assign in_note  = i_s_axis_tdata[nsm_pkg::NOTE_W-1:0];
    assign in_stamp = i_s_axis_tdata[nsm_pkg::NOTE_W +: nsm_pkg::STAMP_W];

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    // history chain: cell 0 takes the new note, each cell feeds the next
    for (genvar g = 0; g < MAX_NOTES; g++) begin : g_cell
        if (g == 0) begin : g_head
            nsm_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (in_xfer),
                .i_note  (in_note),
                .i_stamp (in_stamp),
                .o_note  (cell_note[g]),
                .o_stamp (cell_stamp[g])
            );
        end else begin : g_body
            nsm_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (in_xfer),
                .i_note  (cell_note[g-1]),
                .i_stamp (cell_stamp[g-1]),
                .o_note  (cell_note[g]),
                .o_stamp (cell_stamp[g])
            );
        end
    end

    // window as it stands after the shift: incoming note, then the newest cells
    always_comb begin
        win[0] = in_note;
        for (int i = 1; i < nsm_pkg::PAT_ROW; i++)
            win[i] = cell_note[i-1];
    end

    // a pause longer than the timeout drops the held notes before the push
    assign elapsed   = in_stamp - r_last_stamp;
    assign timed_out = r_note_held && (elapsed > nsm_pkg::STAMP_W'(r_timeout));
    assign cnt_base  = timed_out ? '0 : r_held_count;
    assign cnt_new   = (cnt_base == CNT_W'(MAX_NOTES)) ? cnt_base : cnt_base + 1'b1;

    nsm_match #(
        .CNT_W (CNT_W)
    ) u_match (
        .i_win         (win),
        .i_count       (cnt_new),
        .i_stamp_new   (in_stamp),
        .i_stamp_first (cell_stamp[nsm_pkg::DBL_GAPS - 1]),
        .i_limit       (r_limit),
        .o_result      (result)
    );

    // any match empties the history; last stamp always follows the input
    always_comb begin
        n_held_count = r_held_count;
        n_note_held  = r_note_held;
        if (in_xfer) begin
            n_held_count = result.matched ? '0 : cnt_new;
            n_note_held  = !result.matched;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_count <= '0;
            r_note_held  <= 1'b0;
            r_last_stamp <= '0;
            r_timeout    <= nsm_pkg::TIMEOUT_RESET;
            r_limit      <= nsm_pkg::LIMIT_W'(nsm_pkg::BRISK_RESET)
                            * nsm_pkg::LIMIT_W'(nsm_pkg::DBL_GAPS);
            r_out_valid  <= 1'b0;
        end else begin
            r_held_count <= n_held_count;
            r_note_held  <= n_note_held;
            if (in_xfer)
                r_last_stamp <= in_stamp;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    nsm_pkg::REG_TIMEOUT: r_timeout <= i_cfg_data;
                    nsm_pkg::REG_BRISK:   r_limit   <= nsm_pkg::LIMIT_W'(i_cfg_data)
                                                       * nsm_pkg::LIMIT_W'(nsm_pkg::DBL_GAPS);
                    default:              r_timeout <= r_timeout;
                endcase
            end
            if (in_xfer)
                r_out_valid <= 1'b1;
            else if (i_m_axis_tready)
                r_out_valid <= 1'b0;
        end
    end

    // result payload register
    always_ff @(posedge i_clk) begin
        if (in_xfer)
            r_out <= result;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out.performance, r_out.pattern_index, r_out.matched};

endmodule
`default_nettype wire
